// ===== rtl/vr2d_pkg.sv =====
package vr2d_pkg;

	localparam int FRAC_BITS = 14;
	localparam int HALF      = 1 << (FRAC_BITS - 1);
	localparam int ONE2      = 1 << (2 * FRAC_BITS);

	localparam int COS_W   = 19;
	localparam int R2_W    = 19;
	localparam int S_W     = 24;
	localparam int RC_W    = 22;
	localparam int SQ_IN_W = 40;
	localparam int ROOT_W  = SQ_IN_W / 2;
	localparam int CO_W    = 24;

	// Everything that rides alongside the square root pipeline.
	typedef struct packed {
		logic signed [RC_W-1:0] rc;
		logic signed [15:0]     nx;
		logic signed [15:0]     ny;
		logic signed [32:0]     rvx;
		logic signed [32:0]     rvy;
		logic                   blocked;
	} side_t;

endpackage

// ===== rtl/vr2d_sqrt.sv =====
module vr2d_sqrt import vr2d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [SQ_IN_W-1:0]  in_val,
	input  side_t               in_side,
	output logic                out_valid,
	output logic [ROOT_W-1:0]   out_root,
	output side_t               out_side
);
	// One result bit per stage, classic digit-by-digit integer square root.
	logic [SQ_IN_W-1:0] rem_sk  [ROOT_W+1];
	logic [SQ_IN_W-1:0] res_sk  [ROOT_W+1];
	side_t              side_sk [ROOT_W+1];
	logic               vld_sk  [ROOT_W+1];

	assign rem_sk[0]  = in_val;
	assign res_sk[0]  = '0;
	assign side_sk[0] = in_side;
	assign vld_sk[0]  = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [SQ_IN_W-1:0] trial;
		logic               take;
		assign trial = res_sk[k] + BIT;
		assign take  = rem_sk[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			side_sk[k+1] <= side_sk[k];
			if (take) begin
				rem_sk[k+1] <= rem_sk[k] - trial;
				res_sk[k+1] <= (res_sk[k] >> 1) + BIT;
			end else begin
				rem_sk[k+1] <= rem_sk[k];
				res_sk[k+1] <= res_sk[k] >> 1;
			end
		end
	end

	assign out_valid = vld_sk[ROOT_W];
	assign out_root  = res_sk[ROOT_W][ROOT_W-1:0];
	assign out_side  = side_sk[ROOT_W];

endmodule

// ===== rtl/vector_refract_2d_unit.sv =====
// 2D Snell refraction of a Q2.14 direction vector at a surface with normal
// (normal_x, normal_y) and index ratio index_ratio. The unit is fully
// pipelined: a request is taken in every cycle (busy is always low) and its
// result appears with done, in request order. The pipeline is made of the
// 20-stage square root, one root bit per stage, plus nine multiply and
// rounding stages. There is no back pressure: the result is on the outputs
// for the single cycle that done is high. blocked marks total internal
// reflection (outputs zero); saturated marks a clipped component.
module vector_refract_2d_unit import vr2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic        [15:0] index_ratio,
	output logic               done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic               blocked,
	output logic               saturated
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	assign busy = 1'b0;

	// Stage 1: input products.
	logic signed [31:0] pxx_s1, pyy_s1;
	logic        [31:0] rr_s1;
	logic signed [32:0] rvx_s1, rvy_s1;
	logic        [15:0] r_s1;
	logic signed [15:0] nx_s1, ny_s1;
	logic signed [16:0] r_ext;
	assign r_ext = signed'({1'b0, index_ratio});

	always_ff @(posedge clk) begin
		pxx_s1 <= in_x * normal_x;
		pyy_s1 <= in_y * normal_y;
		rr_s1  <= index_ratio * index_ratio;
		rvx_s1 <= r_ext * in_x;
		rvy_s1 <= r_ext * in_y;
		r_s1   <= index_ratio;
		nx_s1  <= normal_x;
		ny_s1  <= normal_y;
	end

	// Stage 2: cosI and r squared.
	logic signed [33:0] nd, ndr;
	logic        [32:0] rrr;
	assign nd  = -(34'(pxx_s1) + 34'(pyy_s1));
	assign ndr = nd + 34'(HALF);
	assign rrr = {1'b0, rr_s1} + 33'(HALF);

	logic signed [COS_W-1:0] cos_s2;
	logic        [R2_W-1:0]  r2_s2;
	logic        [15:0]      r_s2;
	logic signed [32:0]      rvx_s2, rvy_s2;
	logic signed [15:0]      nx_s2, ny_s2;

	always_ff @(posedge clk) begin
		cos_s2 <= COS_W'(ndr >>> FRAC_BITS);
		r2_s2  <= R2_W'(rrr >> FRAC_BITS);
		r_s2   <= r_s1;
		rvx_s2 <= rvx_s1;
		rvy_s2 <= rvy_s1;
		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
	end

	// Stage 3: cosI squared and r times cosI.
	logic signed [37:0]     csq_s3;
	logic signed [35:0]     rci_s3;
	logic        [R2_W-1:0] r2_s3;
	logic signed [32:0]     rvx_s3, rvy_s3;
	logic signed [15:0]     nx_s3, ny_s3;

	always_ff @(posedge clk) begin
		csq_s3 <= cos_s2 * cos_s2;
		rci_s3 <= signed'({1'b0, r_s2}) * cos_s2;
		r2_s3  <= r2_s2;
		rvx_s3 <= rvx_s2;
		rvy_s3 <= rvy_s2;
		nx_s3  <= nx_s2;
		ny_s3  <= ny_s2;
	end

	// Stage 4: rounding of s and r*cosI.
	logic signed [38:0] sv;
	logic signed [36:0] rcv;
	assign sv  = 39'(ONE2) - 39'(csq_s3) + 39'(HALF);
	assign rcv = 37'(rci_s3) + 37'(HALF);

	logic signed [S_W-1:0]  s_s4;
	logic signed [RC_W-1:0] rc_s4;
	logic        [R2_W-1:0] r2_s4;
	logic signed [32:0]     rvx_s4, rvy_s4;
	logic signed [15:0]     nx_s4, ny_s4;

	always_ff @(posedge clk) begin
		s_s4   <= S_W'(sv >>> FRAC_BITS);
		rc_s4  <= RC_W'(rcv >>> FRAC_BITS);
		r2_s4  <= r2_s3;
		rvx_s4 <= rvx_s3;
		rvy_s4 <= rvy_s3;
		nx_s4  <= nx_s3;
		ny_s4  <= ny_s3;
	end

	// Stage 5: r2 * s.
	logic signed [44:0]     prod_s5;
	logic signed [RC_W-1:0] rc_s5;
	logic signed [32:0]     rvx_s5, rvy_s5;
	logic signed [15:0]     nx_s5, ny_s5;

	always_ff @(posedge clk) begin
		prod_s5 <= signed'({1'b0, r2_s4}) * s_s4;
		rc_s5   <= rc_s4;
		rvx_s5  <= rvx_s4;
		rvy_s5  <= rvy_s4;
		nx_s5   <= nx_s4;
		ny_s5   <= ny_s4;
	end

	// Stage 6: cosT2 and the total internal reflection decision.
	logic signed [45:0] ct2;
	logic               blk;
	assign ct2 = 46'(ONE2) - 46'(prod_s5);
	assign blk = ct2 <= 46'sd0;

	logic [SQ_IN_W-1:0] ct2_s6;
	side_t              side_s6;

	always_ff @(posedge clk) begin
		ct2_s6          <= blk ? '0 : ct2[SQ_IN_W-1:0];
		side_s6.rc      <= rc_s5;
		side_s6.nx      <= nx_s5;
		side_s6.ny      <= ny_s5;
		side_s6.rvx     <= rvx_s5;
		side_s6.rvy     <= rvy_s5;
		side_s6.blocked <= blk;
	end

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	vr2d_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_val    (ct2_s6),
		.in_side   (side_s6),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Stage 7: coefficient along the normal.
	logic signed [CO_W-1:0] coeff_s7;
	side_t                  side_s7;

	always_ff @(posedge clk) begin
		coeff_s7 <= CO_W'(sq_side.rc) - signed'(CO_W'({1'b0, sq_root}));
		side_s7  <= sq_side;
	end

	// Stage 8: coeff times normal.
	logic signed [39:0] mx_s8, my_s8;
	logic signed [32:0] rvx_s8, rvy_s8;
	logic               blk_s8;

	always_ff @(posedge clk) begin
		mx_s8  <= coeff_s7 * side_s7.nx;
		my_s8  <= coeff_s7 * side_s7.ny;
		rvx_s8 <= side_s7.rvx;
		rvy_s8 <= side_s7.rvy;
		blk_s8 <= side_s7.blocked;
	end

	// Stage 9: sum, round, saturate.
	logic signed [40:0] sx, sy;
	logic signed [26:0] rx, ry;
	logic               clx, cly;
	logic signed [15:0] qx, qy;
	assign sx  = 41'(rvx_s8) + 41'(mx_s8) + 41'(HALF);
	assign sy  = 41'(rvy_s8) + 41'(my_s8) + 41'(HALF);
	assign rx  = 27'(sx >>> FRAC_BITS);
	assign ry  = 27'(sy >>> FRAC_BITS);
	assign clx = (rx > 27'sd32767) || (rx < -27'sd32768);
	assign cly = (ry > 27'sd32767) || (ry < -27'sd32768);
	assign qx  = (rx > 27'sd32767) ? 16'sh7fff : (rx < -27'sd32768) ? -16'sh8000 : rx[15:0];
	assign qy  = (ry > 27'sd32767) ? 16'sh7fff : (ry < -27'sd32768) ? -16'sh8000 : ry[15:0];

	always_ff @(posedge clk) begin
		out_x     <= blk_s8 ? '0 : qx;
		out_y     <= blk_s8 ? '0 : qy;
		blocked   <= blk_s8;
		saturated <= !blk_s8 && (clx || cly);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= sq_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign done = v_s9;

`ifndef SYNTHESIS
	a_blk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && blocked |-> out_x == 16'sd0 && out_y == 16'sd0)
		else $error("blocked result is not zero");
	a_blk_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(blocked && saturated))
		else $error("blocked and saturated together");
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> out_x == 16'sh7fff || out_x == -16'sh8000 ||
			out_y == 16'sh7fff || out_y == -16'sh8000)
		else $error("saturated flag without a clipped component");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |=> done)
		else $error("pipeline lost a request");
`endif

endmodule
